FILE: rtl/pcicfg_pkg.sv
package pcicfg_pkg;

    // request and response payloads
    typedef struct packed {
        logic        req_type;
        logic [15:0] port;
        logic [2:0]  byte_count;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic        read_valid;
        logic [31:0] read_data;
    } t_rsp;

    localparam int REG_IDX_W = 6;

    // request kinds after decode
    localparam logic [1:0] OP_NONE    = 2'd0;
    localparam logic [1:0] OP_ADDR_RD = 2'd1;
    localparam logic [1:0] OP_CFG_RD  = 2'd2;
    localparam logic [1:0] OP_CFG_WR  = 2'd3;

    localparam logic       REQ_READ  = 1'b0;
    localparam logic       REQ_WRITE = 1'b1;

    localparam logic [2:0] FULL_DWORD = 3'd4;

    // identity words of the bridge
    localparam logic [31:0] ID_WORD    = 32'h0D57_8086;
    localparam logic [31:0] CLASS_WORD = 32'h0600_0000;
    localparam logic [31:0] HDR_WORD   = 32'h0001_0000;

    // decoded request held in the input stage
    typedef struct packed {
        logic [1:0]           op;
        logic [REG_IDX_W-1:0] idx;
        logic [1:0]           offset;
        logic [2:0]           nbytes;
        logic                 match;
        logic [31:0]          data;
    } t_stage;

    function automatic logic [31:0] reset_word(input logic [REG_IDX_W-1:0] idx);
        logic [31:0] w;
        w = '0;
        if (idx == REG_IDX_W'(0)) w = ID_WORD;
        if (idx == REG_IDX_W'(2)) w = CLASS_WORD;
        if (idx == REG_IDX_W'(3)) w = HDR_WORD;
        return w;
    endfunction

    function automatic logic [31:0] lane_mask(input logic [2:0] n);
        logic [31:0] m;
        m = '0;
        unique case (n)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/pcicfg_ram.sv
module pcicfg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pci_config_space_access.sv
// pci configuration mechanism 1 host bridge. each request is one i/o port read or
// write: full-dword accesses at ADDRESS_PORT load or return the 32-bit address
// register, and accesses at the four byte lanes from DATA_PORT reach the dword
// config register picked by address bits 7:2 when address bit 31 is set. only bus 0,
// device 0, function 0 answers; other devices read as all ones and drop writes.
// every request gives exactly one response. throughput is one request per cycle
// while i_ready stays high; the accepting edge decodes the port, loads the input
// stage and starts the config ram read, then the input stage retires into the
// output register, merging the byte lanes (read-modify-write of the simple dual-port
// config ram) and raising o_valid. a response held by a low i_ready keeps the next
// request in the input stage and o_ready low until it drains. the config store comes
// out of reset holding the identity words at once, with no clearing pass.
module pci_config_space_access #(
    parameter int NUM_REGS     = 64,
    parameter int ADDRESS_PORT = 3320,
    parameter int DATA_PORT    = 3324
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  pcicfg_pkg::t_req     i_req,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pcicfg_pkg::t_rsp     o_rsp
);

    // only 64 dwords are addressable through bits 7:2
    localparam int DEPTH  = (NUM_REGS < 64) ? NUM_REGS : 64;
    localparam int ADDR_W = $clog2(DEPTH);

    // address register and decode of the incoming request
    logic [31:0]                     r_addr;
    logic                            accept;
    logic                            is_addr_port;
    logic [16:0]                     data_diff;
    logic                            is_data_port;
    logic                            in_range;
    logic [2:0]                      lanes_left;
    pcicfg_pkg::t_stage              n_stage;

    // input stage
    logic                            r_s1_valid;
    pcicfg_pkg::t_stage              r_s1;
    logic                            s1_adv;

    // forwarding of a write that commits while the next read is issued
    logic                            r_fwd_hit;
    logic [31:0]                     r_fwd_word;

    // config store
    logic [DEPTH-1:0]                r_vld;
    logic [31:0]                     ram_q;
    logic [31:0]                     old_word;
    logic [31:0]                     mask;
    logic [4:0]                      shamt;
    logic [31:0]                     rd_word;
    logic [31:0]                     new_word;
    logic                            wr_en;

    // output register
    logic                            r_out_valid;
    pcicfg_pkg::t_rsp                r_out;
    pcicfg_pkg::t_rsp                n_out;

    assign accept = i_valid && o_ready;
    assign s1_adv = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_adv;

    // port decode, address port wins over an overlapping data port
    always_comb begin
        is_addr_port = (i_req.port == ADDRESS_PORT[15:0]);
        data_diff    = {1'b0, i_req.port} - {1'b0, DATA_PORT[15:0]};
        is_data_port = !data_diff[16] && (data_diff[15:2] == '0);
        in_range     = ({26'd0, r_addr[7:2]} < 32'(NUM_REGS));
        lanes_left   = 3'd4 - {1'b0, data_diff[1:0]};

        n_stage.idx    = r_addr[7:2];
        n_stage.offset = data_diff[1:0];
        n_stage.nbytes = (i_req.byte_count > lanes_left) ? lanes_left : i_req.byte_count;
        // bus, device and function all zero
        n_stage.match  = (r_addr[23:8] == '0);
        n_stage.data   = i_req.write_data;
        n_stage.op     = pcicfg_pkg::OP_NONE;

        priority if (is_addr_port) begin
            if (i_req.byte_count == pcicfg_pkg::FULL_DWORD &&
                i_req.req_type == pcicfg_pkg::REQ_READ) begin
                n_stage.op   = pcicfg_pkg::OP_ADDR_RD;
                n_stage.data = r_addr;
            end
        end else if (is_data_port && r_addr[31] && in_range) begin
            n_stage.op = (i_req.req_type == pcicfg_pkg::REQ_WRITE) ?
                         pcicfg_pkg::OP_CFG_WR : pcicfg_pkg::OP_CFG_RD;
        end else begin
            n_stage.op = pcicfg_pkg::OP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (accept && is_addr_port && i_req.req_type == pcicfg_pkg::REQ_WRITE &&
                     i_req.byte_count == pcicfg_pkg::FULL_DWORD) begin
            r_addr <= i_req.write_data;
        end
    end

    // input stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_fwd_hit  <= wr_en && (r_s1.idx == n_stage.idx);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1       <= n_stage;
            r_fwd_word <= new_word;
        end
    end

    // config ram, read issued at acceptance, written when the stage retires
    pcicfg_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1.idx[ADDR_W-1:0]),
        .i_wdata (new_word),
        .i_re    (accept),
        .i_raddr (n_stage.idx[ADDR_W-1:0]),
        .o_rdata (ram_q)
    );

    // entries never written read as their reset word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[r_s1.idx[ADDR_W-1:0]] <= 1'b1;
        end
    end

    // byte lane merge
    always_comb begin
        if (r_fwd_hit) begin
            old_word = r_fwd_word;
        end else if (r_vld[r_s1.idx[ADDR_W-1:0]]) begin
            old_word = ram_q;
        end else begin
            old_word = pcicfg_pkg::reset_word(r_s1.idx);
        end
        mask     = pcicfg_pkg::lane_mask(r_s1.nbytes);
        shamt    = {r_s1.offset, 3'b000};
        rd_word  = r_s1.match ? ((old_word >> shamt) & mask) : mask;
        new_word = (old_word & ~(mask << shamt)) | ((r_s1.data & mask) << shamt);
        wr_en    = s1_adv && (r_s1.op == pcicfg_pkg::OP_CFG_WR) && r_s1.match;
    end

    always_comb begin
        unique case (r_s1.op)
            pcicfg_pkg::OP_ADDR_RD: begin
                n_out.read_valid = 1'b1;
                n_out.read_data  = r_s1.data;
            end
            pcicfg_pkg::OP_CFG_RD: begin
                n_out.read_valid = 1'b1;
                n_out.read_data  = rd_word;
            end
            default: begin
                n_out.read_valid = 1'b0;
                n_out.read_data  = '0;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    // a response without read data carries zero data
    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.read_valid |-> o_rsp.read_data == '0)
        else $error("response without read data has nonzero data");

    // a config write commits only for the answering function
    a_wr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_s1_valid && r_s1.match && r_s1.op == pcicfg_pkg::OP_CFG_WR)
        else $error("config write committed for a non-matching request");

    // a stalled input stage keeps its request
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_ready |=>
        r_s1_valid && $stable(r_s1.op) && $stable(r_s1.idx))
        else $error("input stage changed while stalled");

    // forwarding only targets the request that was just issued
    a_fwd_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && wr_en && r_s1.idx == n_stage.idx |=> r_fwd_hit && r_s1_valid)
        else $error("write forwarding missed");

endmodule
